### rtl/rau_pkg.sv
// Package for the rational arithmetic unit: opcodes, error codes, field widths,
// and the command/status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package rau_pkg;

  localparam int MAG_WIDTH_DEF = 16;
  localparam int OP_W          = 3;
  localparam int ERR_W         = 2;
  localparam int NUM_W         = 33;
  localparam int DEN_W         = 32;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_RED = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ZERO_DEN = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd2;

  // multiplier step selects
  localparam logic [1:0] MS_AN_BD = 2'd0;
  localparam logic [1:0] MS_BN_AD = 2'd1;
  localparam logic [1:0] MS_DEN   = 2'd2;
  localparam logic [1:0] MS_AN_BN = 2'd3;

  // width of the unreduced numerator/denominator, capped at 64 bits
  function automatic int gcd_width(input int m);
    return (2 * m + 1 > 64) ? 64 : 2 * m + 1;
  endfunction

  typedef struct packed {
    logic       req_ready;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       form;
    logic       gcd_init;
    logic       gcd_step;
    logic       g_load;
    logic       div_init;
    logic       div_den;
    logic       div_step;
    logic       store_num;
    logic       store_den;
    logic       out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic req_fire;
    logic trivial;
    logic gcd_done;
    logic out_free;
  } rau_stat_t;

endpackage

### rtl/rau_if.sv
// Valid/ready channel interfaces for the request and result beats.
// Depends on rau_pkg.
`timescale 1ns / 1ps

interface rau_req_if #(
  parameter int MAG_WIDTH = rau_pkg::MAG_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic [rau_pkg::OP_W-1:0]    opcode;
  logic                        a_negative;
  logic [MAG_WIDTH-1:0]        a_num;
  logic [MAG_WIDTH-1:0]        a_den;
  logic                        b_negative;
  logic [MAG_WIDTH-1:0]        b_num;
  logic [MAG_WIDTH-1:0]        b_den;

  modport source (output valid, opcode, a_negative, a_num, a_den, b_negative, b_num, b_den,
                  input ready);
  modport sink   (input valid, opcode, a_negative, a_num, a_den, b_negative, b_num, b_den,
                  output ready);
endinterface

interface rau_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        res_negative;
  logic [rau_pkg::NUM_W-1:0]   res_num;
  logic [rau_pkg::DEN_W-1:0]   res_den;
  logic                        a_less;
  logic                        a_equal;
  logic [rau_pkg::ERR_W-1:0]   error;

  modport source (output valid, res_negative, res_num, res_den, a_less, a_equal, error,
                  input ready);
  modport sink   (input valid, res_negative, res_num, res_den, a_less, a_equal, error,
                  output ready);
endinterface

### rtl/rau_datapath.sv
// Datapath: operand capture, shared multiplier, sign/magnitude combine, binary GCD,
// restoring divider and result register. Depends on rau_pkg and rau_if.
`timescale 1ns / 1ps

module rau_datapath #(
  parameter int MAG_WIDTH = rau_pkg::MAG_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  rau_req_if.sink           req,
  rau_rsp_if.source         rsp,
  input  rau_pkg::rau_cmd_t cmd,
  output rau_pkg::rau_stat_t stat
);

  localparam int M  = MAG_WIDTH;
  localparam int P  = 2 * M;
  localparam int W  = rau_pkg::gcd_width(M);
  localparam int KW = $clog2(W + 1);

  logic [rau_pkg::OP_W-1:0] op;
  logic                     a_neg, b_neg;
  logic [M-1:0]             an, ad, bn, bd;
  logic [P-1:0]             p, q, d, m;
  logic [M-1:0]             mul_a, mul_b;
  logic [P-1:0]             prod;

  logic [W-1:0]             num, den, x, y, g, rem, quo, rnum, rden;
  logic [KW-1:0]            k;
  logic                     neg, less, equal;
  logic [rau_pkg::ERR_W-1:0] err;

  logic                     sa, sb, sbe, cmp_ok, f_neg, f_less, f_equal;
  logic [W-1:0]             f_num, f_den, pw, qw;
  logic [rau_pkg::ERR_W-1:0] f_err;
  logic [W:0]               rem_sh;
  logic                     rem_ge;
  logic                     out_valid;

  assign req.ready     = cmd.req_ready;
  assign stat.req_fire = req.valid && cmd.req_ready;

  always_ff @(posedge clk) begin
    if (stat.req_fire) begin
      op    <= (req.opcode > rau_pkg::OP_RED) ? rau_pkg::OP_RED : req.opcode;
      a_neg <= req.a_negative;
      an    <= req.a_num;
      ad    <= req.a_den;
      b_neg <= req.b_negative;
      bn    <= req.b_num;
      bd    <= req.b_den;
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      rau_pkg::MS_AN_BD: begin mul_a = an; mul_b = bd; end
      rau_pkg::MS_BN_AD: begin mul_a = bn; mul_b = ad; end
      rau_pkg::MS_DEN:   begin mul_a = ad; mul_b = (op == rau_pkg::OP_DIV) ? bn : bd; end
      rau_pkg::MS_AN_BN: begin mul_a = an; mul_b = bn; end
    endcase
  end

  assign prod = {{M{1'b0}}, mul_a} * {{M{1'b0}}, mul_b};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        rau_pkg::MS_AN_BD: p <= prod;
        rau_pkg::MS_BN_AD: q <= prod;
        rau_pkg::MS_DEN:   d <= prod;
        rau_pkg::MS_AN_BN: m <= prod;
      endcase
    end
  end

  // combine signs and magnitudes
  always_comb begin
    sa      = a_neg && (an != '0);
    sb      = b_neg && (bn != '0);
    pw      = W'(p);
    qw      = W'(q);
    cmp_ok  = (ad != '0) && (bd != '0);
    f_less  = 1'b0;
    f_equal = 1'b0;
    if (cmp_ok) begin
      if (sa != sb) begin
        f_less = sa;
      end else begin
        f_equal = (p == q);
        f_less  = sa ? (p > q) : (p < q);
      end
    end
    sbe = ((op == rau_pkg::OP_SUB) ? !sb : sb) && (bn != '0);
    unique case (op)
      rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
        f_den = W'(d);
        if (sa == sbe) begin
          f_num = pw + qw;
          f_neg = sa;
        end else if (p >= q) begin
          f_num = pw - qw;
          f_neg = sa;
        end else begin
          f_num = qw - pw;
          f_neg = sbe;
        end
      end
      rau_pkg::OP_MUL: begin
        f_num = W'(m);
        f_den = W'(d);
        f_neg = sa ^ sb;
      end
      rau_pkg::OP_DIV: begin
        f_num = pw;
        f_den = W'(d);
        f_neg = sa ^ sb;
      end
      default: begin
        f_num = W'(an);
        f_den = W'(ad);
        f_neg = sa;
      end
    endcase
    if (ad == '0 || (op != rau_pkg::OP_RED && bd == '0)) begin
      f_err = rau_pkg::ERR_ZERO_DEN;
    end else if (op == rau_pkg::OP_DIV && bn == '0) begin
      f_err = rau_pkg::ERR_DIV_ZERO;
    end else begin
      f_err = rau_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.form) begin
      num   <= (f_err != rau_pkg::ERR_NONE) ? '0 : f_num;
      den   <= (f_err != rau_pkg::ERR_NONE) ? W'(1) : f_den;
      neg   <= f_neg;
      less  <= f_less;
      equal <= f_equal;
      err   <= f_err;
    end
  end

  assign stat.trivial = (num == '0) || (den == '0);

  // binary GCD, one step per cycle
  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      x <= num;
      y <= den;
      k <= '0;
    end else if (cmd.gcd_step) begin
      priority if (!x[0] && !y[0]) begin
        x <= x >> 1;
        y <= y >> 1;
        k <= k + KW'(1);
      end else if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x >= y) begin
        x <= x - y;
      end else begin
        y <= y - x;
      end
    end
    if (cmd.g_load) begin
      g <= (x | y) << k;
    end
  end

  assign stat.gcd_done = (x == '0) || (y == '0);

  // restoring divide by g, one quotient bit per cycle
  assign rem_sh = {rem, quo[W-1]};
  assign rem_ge = rem_sh >= {1'b0, g};

  always_ff @(posedge clk) begin
    if (cmd.store_num) begin
      rnum <= quo;
    end
    if (cmd.store_den) begin
      rden <= quo;
    end
    if (cmd.div_init) begin
      rem <= '0;
      quo <= cmd.div_den ? den : num;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? W'(rem_sh - {1'b0, g}) : W'(rem_sh);
      quo <= {quo[W-2:0], rem_ge};
    end
  end

  assign stat.out_free = !out_valid || rsp.ready;
  assign rsp.valid     = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.res_negative <= neg && !stat.trivial;
      rsp.res_num      <= stat.trivial ? '0 : rau_pkg::NUM_W'(rnum);
      rsp.res_den      <= stat.trivial ? rau_pkg::DEN_W'(1) : rau_pkg::DEN_W'(rden);
      rsp.a_less       <= less;
      rsp.a_equal      <= equal;
      rsp.error        <= err;
    end
  end

endmodule

### rtl/rau_ctrl.sv
// Controller: one-hot sequencer over multiply, combine, GCD, divide and output steps.
// Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_ctrl #(
  parameter int MAG_WIDTH = rau_pkg::MAG_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_cmd_t  cmd
);

  localparam int W  = rau_pkg::gcd_width(MAG_WIDTH);
  localparam int CW = $clog2(W + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_FORM  = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_GCD   = 8'b0001_0000,
    S_DIVN  = 8'b0010_0000,
    S_DIVD  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_sel = cnt[1:0];
    unique case (state)
      S_IDLE: begin
        cmd.req_ready = 1'b1;
        if (stat.req_fire) begin
          state_next = S_MUL;
          cnt_next   = '0;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_next   = cnt + CW'(1);
        if (cnt[1:0] == rau_pkg::MS_AN_BN) begin
          state_next = S_FORM;
        end
      end
      S_FORM: begin
        cmd.form   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.trivial) begin
          state_next = S_DONE;
        end else begin
          cmd.gcd_init = 1'b1;
          state_next   = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          cmd.g_load   = 1'b1;
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        if (cnt == CW'(W)) begin
          cmd.store_num = 1'b1;
          cmd.div_init  = 1'b1;
          cmd.div_den   = 1'b1;
          cnt_next      = '0;
          state_next    = S_DIVD;
        end else begin
          cmd.div_step = 1'b1;
          cnt_next     = cnt + CW'(1);
        end
      end
      S_DIVD: begin
        if (cnt == CW'(W)) begin
          cmd.store_den = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
          cnt_next     = cnt + CW'(1);
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/rational_arithmetic_unit.sv
// Channel   Dir  Payload
// req       in   opcode, a_negative, a_num, a_den, b_negative, b_num, b_den
// rsp       out  res_negative, res_num, res_den, a_less, a_equal, error
//
// One beat at a time. Error and zero results skip the GCD and divide steps and go straight
// to the rsp register; otherwise the binary GCD loop runs, then the one-bit divider divides
// the numerator and then the denominator by the GCD, all on W = min(2*MAG_WIDTH+1, 64) bits.
// Reset (rst, synchronous) returns the sequencer to idle and drops rsp.valid.
// req.ready is low until the result is loaded into the rsp register; a stalled rsp holds.
// Depends on rau_pkg, rau_if, rau_ctrl, rau_datapath.
`timescale 1ns / 1ps

module rational_arithmetic_unit #(
  parameter int MAG_WIDTH = rau_pkg::MAG_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  rau_req_if.sink   req,
  rau_rsp_if.source rsp
);

  rau_pkg::rau_cmd_t  cmd;
  rau_pkg::rau_stat_t stat;

  rau_ctrl #(.MAG_WIDTH(MAG_WIDTH)) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  rau_datapath #(.MAG_WIDTH(MAG_WIDTH)) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

### rtl/rau_checker.sv
// Port-level checks on the result channel of the rational arithmetic unit, and the bind.
// Depends on rau_pkg and rational_arithmetic_unit.
`timescale 1ns / 1ps

module rau_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       res_negative,
  input logic [rau_pkg::NUM_W-1:0]  res_num,
  input logic [rau_pkg::DEN_W-1:0]  res_den,
  input logic                       a_less,
  input logic                       a_equal,
  input logic [rau_pkg::ERR_W-1:0]  error
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_num) && $stable(res_den))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error != rau_pkg::ERR_NONE |-> res_num == '0 && res_den == 1 && !res_negative)
    else $error("error beat carries a value");

  a_zero_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && res_num == '0 |-> res_den == 1 && !res_negative)
    else $error("zero result not 0/1 positive");

  a_cmp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(a_less && a_equal) && res_den != '0)
    else $error("inconsistent compare flags or zero denominator");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .res_negative (rsp.res_negative),
  .res_num      (rsp.res_num),
  .res_den      (rsp.res_den),
  .a_less       (rsp.a_less),
  .a_equal      (rsp.a_equal),
  .error        (rsp.error)
);
